// ===== src/uart_rx_fifo_port_interface_core_assert.svh =====
// Assertion macros of the receive FIFO interface RTL.
`ifndef UART_RX_FIFO_PORT_INTERFACE_CORE_ASSERT_SVH
`define UART_RX_FIFO_PORT_INTERFACE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define UARTRX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uartrx assertion failed");

// Next-cycle implication, disabled while in reset.
`define UARTRX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uartrx assertion failed");

`endif

// ===== src/uartrx_pkg.sv =====
// Package with types, constants and helpers of the receive FIFO interface.
package uartrx_pkg;

  localparam int FIFO_DEPTH = 256;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CLEAR_CODE  = 8'd20;
  localparam logic [7:0] SPEED_COUNT = 8'd10;
  localparam logic [7:0] EMPTY_READ  = 8'hFF;
  localparam int         SPD_W       = 4;
  localparam int         BAUD_W      = 20;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_PRESENT = '0;

  typedef enum logic [2:0] {
    KIND_DATA_READ   = 3'd0,
    KIND_STATUS_READ = 3'd1,
    KIND_CMD_WRITE   = 3'd2,
    KIND_TX_WRITE    = 3'd3,
    KIND_RX_BYTE     = 3'd4
  } kind_t;

  typedef struct packed {
    logic              valid;
    logic [7:0]        read_data;
    logic              tx_strobe;
    logic [7:0]        tx_byte;
    logic [BAUD_W-1:0] baud_rate;
  } res_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [BAUD_W-1:0] speed_of(input logic [SPD_W-1:0] idx);
    logic [BAUD_W-1:0] r;
    unique case (idx)
      4'd1:    r = 20'd346520;
      4'd2:    r = 20'd231014;
      4'd3:    r = 20'd115200;
      4'd4:    r = 20'd57600;
      4'd5:    r = 20'd38400;
      4'd6:    r = 20'd31250;
      4'd7:    r = 20'd19200;
      4'd8:    r = 20'd9600;
      4'd9:    r = 20'd4800;
      default: r = 20'd859372;
    endcase
    return r;
  endfunction

endpackage

// ===== src/uartrx_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module uartrx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/uartrx_ctrl.sv =====
// Transaction control: FIFO pointers, flags, speed select and result register.
module uartrx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [2:0]        kind,
  input  logic [7:0]        value,
  input  logic              port_present,
  output uartrx_pkg::res_t  res_o
);
  import uartrx_pkg::*;

  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic              und_r, und_nxt;
  logic [SPD_W-1:0]  spd_r, spd_nxt;
  logic              valid_r;
  logic              use_ram_r, use_ram;
  logic [7:0]        rd_r, rd;
  logic              strobe_r, strobe;
  logic [7:0]        txb_r, txb;
  logic [BAUD_W-1:0] baud_r;
  logic              ram_we;
  logic [7:0]        ram_rdata;
  logic              empty, full;

  assign empty = (rp_r == wp_r);
  assign full  = (ring_next(wp_r) == rp_r);

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    und_nxt = und_r;
    spd_nxt = spd_r;
    use_ram = 1'b0;
    rd      = '0;
    strobe  = 1'b0;
    txb     = '0;
    ram_we  = 1'b0;
    if (accept) begin
      unique case (kind_t'(kind))
        KIND_DATA_READ: begin
          if (!empty) begin
            use_ram = 1'b1;
            rp_nxt  = ring_next(rp_r);
          end else begin
            rd      = EMPTY_READ;
            und_nxt = 1'b1;
          end
        end
        KIND_STATUS_READ: begin
          rd      = {3'b000, und_r, 1'b1, full, 1'b0, !empty};
          und_nxt = 1'b0;
        end
        KIND_CMD_WRITE: begin
          if (value < SPEED_COUNT) begin
            spd_nxt = value[SPD_W-1:0];
          end else if (value == CLEAR_CODE) begin
            wp_nxt = '0;
            rp_nxt = '0;
          end
        end
        KIND_TX_WRITE: begin
          if (port_present) begin
            strobe = 1'b1;
            txb    = value;
          end
        end
        KIND_RX_BYTE: begin
          if (!full) begin
            ram_we = 1'b1;
            wp_nxt = ring_next(wp_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  uartrx_ram #(
    .WIDTH(8),
    .DEPTH(FIFO_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(value),
    .re   (use_ram),
    .raddr(rp_r),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      und_r   <= 1'b0;
      spd_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      und_r   <= und_nxt;
      spd_r   <= spd_nxt;
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      use_ram_r <= use_ram;
      rd_r      <= rd;
      strobe_r  <= strobe;
      txb_r     <= txb;
      baud_r    <= speed_of(spd_nxt);
    end
  end

  always_comb begin
    res_o.valid     = valid_r;
    res_o.read_data = use_ram_r ? ram_rdata : rd_r;
    res_o.tx_strobe = strobe_r;
    res_o.tx_byte   = txb_r;
    res_o.baud_rate = baud_r;
  end

`include "uart_rx_fifo_port_interface_core_assert.svh"

  `UARTRX_ASSERT_IMP(a_ptr_range, 1'b1,
                     (32'(wp_r) < FIFO_DEPTH) && (32'(rp_r) < FIFO_DEPTH))
  `UARTRX_ASSERT_IMP(a_no_write_full, ram_we, !full && accept)
  `UARTRX_ASSERT_NXT(a_result_follows, accept, valid_r)
  `UARTRX_ASSERT_NXT(a_pop_advances, accept && use_ram,
                     (rp_r == ring_next($past(rp_r))) && !und_r == !$past(und_r))
  `UARTRX_ASSERT_IMP(a_speed_range, 1'b1, {4'b0000, spd_r} < SPEED_COUNT)

endmodule

// ===== src/uart_rx_fifo_port_interface_core.sv =====
// Top level of the UART host interface with receive FIFO and status register.
//
// One transaction is accepted in every cycle (busy stays low) and its result
// is on the out_ ports for exactly one cycle, in the cycle after acceptance;
// the result fields are registered, as is the read of the receive store RAM.
// The receiver cannot stall, so results are never held back or queued. The
// port_present register sits at byte address 0 of the APB-style port and
// resets to 1; the store needs no clearing pass after reset.
module uart_rx_fifo_port_interface_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       in_kind,
  input  logic [7:0]                       in_value,
  output logic                             out_valid,
  output logic [7:0]                       out_read_data,
  output logic                             out_tx_strobe,
  output logic [7:0]                       out_tx_byte,
  output logic [uartrx_pkg::BAUD_W-1:0]    out_baud_rate,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [uartrx_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import uartrx_pkg::*;

  logic                 port_present_r;
  logic                 cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 accept;
  res_t                 res;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_present_r <= 1'b1;
    end else if (cfg_wr && cfg_idx == CFG_PORT_PRESENT) begin
      port_present_r <= pwdata[0];
    end
  end

  assign prdata = (cfg_idx == CFG_PORT_PRESENT) ? {31'b0, port_present_r} : '0;

  uartrx_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .kind        (in_kind),
    .value       (in_value),
    .port_present(port_present_r),
    .res_o       (res)
  );

  assign out_valid     = res.valid;
  assign out_read_data = res.read_data;
  assign out_tx_strobe = res.tx_strobe;
  assign out_tx_byte   = res.tx_byte;
  assign out_baud_rate = res.baud_rate;

endmodule
